[src/cbr_pkg.sv]
package cbr_pkg;

  localparam int BUFFER_BYTES = 340;
  localparam int HEADER_BYTES = 10;
  localparam int ADDR_W = $clog2(BUFFER_BYTES);

  localparam int OP_W = 2;
  localparam int BYTE_W = 8;
  localparam int INDEX_W = 9;
  localparam int STATUS_W = 3;
  localparam int LEN_W = 9;
  localparam int COUNT_W = 16;
  localparam int SIZE_W = 33;
  localparam int DLEN_W = 32;

  localparam logic [SIZE_W-1:0] BUF_LIMIT = SIZE_W'(BUFFER_BYTES);
  localparam logic [SIZE_W-1:0] HDR_SIZE = SIZE_W'(HEADER_BYTES);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // operation codes
  localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_EOF  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_CONTINUE     = 3'd0,
    ST_COMPLETE     = 3'd1,
    ST_TOO_SHORT    = 3'd2,
    ST_MISMATCH     = 3'd3,
    ST_OVERSIZE     = 3'd4,
    ST_OVERSIZE_END = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MODE_FIRST   = 2'd0,
    MODE_CONT    = 2'd1,
    MODE_DISCARD = 2'd2
  } mode_t;

endpackage

[src/cbr_in_if.sv]
interface cbr_in_if;
  logic                         valid;
  logic                         ready;
  logic [cbr_pkg::OP_W-1:0]     operation;
  logic [cbr_pkg::BYTE_W-1:0]   frame_byte;
  logic [cbr_pkg::INDEX_W-1:0]  read_index;

  modport source (output valid, operation, frame_byte, read_index, input ready);
  modport sink (input valid, operation, frame_byte, read_index, output ready);
endinterface

[src/cbr_out_if.sv]
interface cbr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic [cbr_pkg::STATUS_W-1:0]  frame_status;
  logic [cbr_pkg::LEN_W-1:0]     message_length;
  logic [cbr_pkg::BYTE_W-1:0]    read_data;

  modport source (output valid, result_kind, frame_status, message_length, read_data,
                  input ready);
  modport sink (input valid, result_kind, frame_status, message_length, read_data,
                output ready);
endinterface

[src/ccid_bulk_out_message_reassembly.sv]
// CCID bulk-out message reassembly.
// frames (sink): one word per item. operation selects a frame byte, an
//   end-of-frame marker, or a read of the message buffer at read_index.
// results (source): one word per end-of-frame (frame status and, when the
//   message is complete, its total length) and one per buffer read.
// Frame bytes give no result; unless discarded, a byte inside the buffer
//   and message is written when accepted; dwLength is captured on the fly.
// Throughput: one item per cycle, sustained, as long as results are taken.
// A result is registered and appears in the cycle after its item is
//   accepted; the buffer is a synchronous RAM with a registered read port.
// frames.ready drops only while a result sits in the output register and
//   results.ready is low; a stalled result holds steady, RAM read data too.
// Reset (rst, synchronous) returns to waiting for a first frame and clears
//   all counters; buffer contents are undefined until written, and reads
//   are meaningful only below the length of a complete message.
module ccid_bulk_out_message_reassembly (
  input  logic       clk,
  input  logic       rst,
  cbr_in_if.sink     frames,
  cbr_out_if.source  results
);

  // message state
  cbr_pkg::mode_t                   mode, mode_next;
  logic [cbr_pkg::SIZE_W-1:0]       bytes_received, bytes_received_next;
  logic [cbr_pkg::SIZE_W-1:0]       bytes_expected, bytes_expected_next;
  logic [cbr_pkg::COUNT_W-1:0]      frame_byte_count, frame_byte_count_next;
  logic [cbr_pkg::DLEN_W-1:0]       declared_length, declared_length_next;

  // output register
  logic                             out_valid;
  logic                             out_kind;
  cbr_pkg::status_t                 out_status;
  logic [cbr_pkg::LEN_W-1:0]        out_len;
  logic                             out_oob;

  // buffer
  logic [cbr_pkg::BYTE_W-1:0]       mem [cbr_pkg::BUFFER_BYTES];
  logic [cbr_pkg::BYTE_W-1:0]       rdata;
  logic                             we;
  logic [cbr_pkg::ADDR_W-1:0]       waddr;
  logic [cbr_pkg::ADDR_W-1:0]       raddr;

  logic                             accept, take_byte, take_eof, take_read;
  logic [cbr_pkg::SIZE_W-1:0]       count_w, sum, exp_new, index_w;
  cbr_pkg::status_t                 eof_status;
  logic [cbr_pkg::LEN_W-1:0]        eof_len;

  assign frames.ready = !out_valid || results.ready;
  assign accept       = frames.valid && frames.ready;
  assign take_byte    = accept && (frames.operation == cbr_pkg::OP_BYTE);
  assign take_eof     = accept && (frames.operation == cbr_pkg::OP_EOF);
  assign take_read    = accept && (frames.operation == cbr_pkg::OP_READ);

  assign count_w = cbr_pkg::SIZE_W'(frame_byte_count);
  // running position: received so far plus bytes in this frame
  assign sum     = bytes_received + count_w;
  assign exp_new = cbr_pkg::SIZE_W'(declared_length) + cbr_pkg::HDR_SIZE;
  assign index_w = cbr_pkg::SIZE_W'(frames.read_index);
  assign raddr   = index_w[cbr_pkg::ADDR_W-1:0];

  // byte write: first frame at its frame position, continuation after the
  // bytes already received and only inside the declared message
  always_comb begin
    we    = 1'b0;
    waddr = count_w[cbr_pkg::ADDR_W-1:0];
    case (mode)
      cbr_pkg::MODE_CONT: begin
        we    = take_byte && (sum < bytes_expected) && (sum < cbr_pkg::BUF_LIMIT);
        waddr = sum[cbr_pkg::ADDR_W-1:0];
      end
      cbr_pkg::MODE_DISCARD: begin
        we = 1'b0;
      end
      default: begin
        we = take_byte && (count_w < cbr_pkg::BUF_LIMIT);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= frames.frame_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (take_read && (index_w < cbr_pkg::BUF_LIMIT)) begin
      rdata <= mem[raddr];
    end
  end

  // next state
  always_comb begin
    mode_next             = mode;
    bytes_received_next   = bytes_received;
    bytes_expected_next   = bytes_expected;
    frame_byte_count_next = frame_byte_count;
    declared_length_next  = declared_length;
    if (take_byte) begin
      if (frame_byte_count != cbr_pkg::COUNT_MAX) begin
        frame_byte_count_next = frame_byte_count + cbr_pkg::COUNT_W'(1);
      end
      if (mode != cbr_pkg::MODE_CONT && mode != cbr_pkg::MODE_DISCARD) begin
        // dwLength, little endian, header bytes 1..4
        case (frame_byte_count)
          16'd1:   declared_length_next[7:0]   = frames.frame_byte;
          16'd2:   declared_length_next[15:8]  = frames.frame_byte;
          16'd3:   declared_length_next[23:16] = frames.frame_byte;
          16'd4:   declared_length_next[31:24] = frames.frame_byte;
          default: ;
        endcase
      end
    end else if (take_eof) begin
      frame_byte_count_next = '0;
      case (mode)
        cbr_pkg::MODE_CONT: begin
          if (sum < bytes_expected) begin
            bytes_received_next = sum;
          end else begin
            mode_next = cbr_pkg::MODE_FIRST;
          end
        end
        cbr_pkg::MODE_DISCARD: begin
          if (sum < bytes_expected) begin
            bytes_received_next = sum;
          end else begin
            mode_next = cbr_pkg::MODE_FIRST;
          end
        end
        default: begin
          mode_next = cbr_pkg::MODE_FIRST;
          if (count_w >= cbr_pkg::HDR_SIZE) begin
            bytes_received_next = count_w;
            bytes_expected_next = exp_new;
            if (exp_new > cbr_pkg::BUF_LIMIT) begin
              mode_next = cbr_pkg::MODE_DISCARD;
            end else if (count_w < exp_new) begin
              mode_next = cbr_pkg::MODE_CONT;
            end
          end
        end
      endcase
    end
  end

  // end-of-frame status
  always_comb begin
    eof_status = cbr_pkg::ST_CONTINUE;
    eof_len    = '0;
    case (mode)
      cbr_pkg::MODE_CONT: begin
        if (sum < bytes_expected) begin
          eof_status = cbr_pkg::ST_CONTINUE;
        end else if (sum == bytes_expected) begin
          eof_status = cbr_pkg::ST_COMPLETE;
          eof_len    = bytes_expected[cbr_pkg::LEN_W-1:0];
        end else begin
          eof_status = cbr_pkg::ST_MISMATCH;
        end
      end
      cbr_pkg::MODE_DISCARD: begin
        eof_status = (sum < bytes_expected) ? cbr_pkg::ST_OVERSIZE
                                            : cbr_pkg::ST_OVERSIZE_END;
      end
      default: begin
        if (count_w < cbr_pkg::HDR_SIZE) begin
          eof_status = cbr_pkg::ST_TOO_SHORT;
        end else if (exp_new > cbr_pkg::BUF_LIMIT) begin
          eof_status = cbr_pkg::ST_OVERSIZE;
        end else if (count_w == exp_new) begin
          eof_status = cbr_pkg::ST_COMPLETE;
          eof_len    = exp_new[cbr_pkg::LEN_W-1:0];
        end else if (count_w < exp_new) begin
          eof_status = cbr_pkg::ST_CONTINUE;
        end else begin
          eof_status = cbr_pkg::ST_MISMATCH;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= cbr_pkg::MODE_FIRST;
      bytes_received   <= '0;
      bytes_expected   <= '0;
      frame_byte_count <= '0;
      declared_length  <= '0;
    end else begin
      mode             <= mode_next;
      bytes_received   <= bytes_received_next;
      bytes_expected   <= bytes_expected_next;
      frame_byte_count <= frame_byte_count_next;
      declared_length  <= declared_length_next;
    end
  end

  // output register; loads only when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_eof || take_read) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_eof) begin
      out_kind   <= cbr_pkg::KIND_STATUS;
      out_status <= eof_status;
      out_len    <= eof_len;
      out_oob    <= 1'b0;
    end else if (take_read) begin
      out_kind   <= cbr_pkg::KIND_READ;
      out_status <= cbr_pkg::ST_CONTINUE;
      out_len    <= '0;
      out_oob    <= (index_w >= cbr_pkg::BUF_LIMIT);
    end
  end

  assign results.valid          = out_valid;
  assign results.result_kind    = out_kind;
  assign results.frame_status   = out_status;
  assign results.message_length = out_len;
  assign results.read_data      = (out_kind == cbr_pkg::KIND_READ && !out_oob) ? rdata : '0;

  // a continuation is always short of the expected size
  a_cont_short: assert property (@(posedge clk) disable iff (rst)
    mode == cbr_pkg::MODE_CONT |-> bytes_received < bytes_expected)
    else $error("continuation with received >= expected");

  // a message being stored fits the buffer
  a_cont_fits: assert property (@(posedge clk) disable iff (rst)
    mode == cbr_pkg::MODE_CONT |-> bytes_expected <= cbr_pkg::BUF_LIMIT)
    else $error("continuation beyond buffer size");

  // a length is reported only with a complete status
  a_len_complete: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != cbr_pkg::ST_COMPLETE |-> out_len == '0)
    else $error("length reported without complete status");

  // an accepted read shows up as a read result next cycle
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    take_read |=> out_valid && out_kind == cbr_pkg::KIND_READ)
    else $error("read result missing");

endmodule
